@@ sv/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IN_VALUE_W      = 64;
    localparam int OPCODE_W        = 3;
    localparam int CHAR_W          = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SDEC = 3'd0,
        OP_UDEC = 3'd1,
        OP_OCT  = 3'd2,
        OP_HEXL = 3'd3,
        OP_HEXU = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        t_radix radix;
        logic   upper;
        logic   neg;
    } t_item_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 4'd10) begin
            return CHAR_ZERO + CHAR_W'(d);
        end else begin
            return base + CHAR_W'(d) - CHAR_W'(10);
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/itoa_if.sv @@
`default_nettype none

interface itoa_in_if;
    logic                             valid;
    logic                             ready;
    logic [itoa_pkg::IN_VALUE_W-1:0]  value;
    logic [itoa_pkg::OPCODE_W-1:0]    opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink   (input valid, input value, input opcode, output ready);
endinterface

interface itoa_out_if;
    logic                         valid;
    logic                         ready;
    logic [itoa_pkg::CHAR_W-1:0]  char_out;
    logic                         last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

@@ sv/itoa_front.sv @@
`default_nettype none

module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    itoa_in_if.sink                 i_in,
    input  wire logic               i_full,
    output logic                    o_push,
    output logic [VALUE_WIDTH-1:0]  o_mag,
    output itoa_pkg::t_item_ctl     o_ctl
);
    import itoa_pkg::*;

    logic [VALUE_WIDTH-1:0] w_num;
    logic                   w_known;

    assign w_num      = i_in.value[VALUE_WIDTH-1:0];
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && w_known;

    always_comb begin
        w_known     = 1'b1;
        o_ctl.radix = RAD_DEC;
        o_ctl.upper = 1'b0;
        o_ctl.neg   = 1'b0;
        o_mag       = w_num;
        unique case (t_opcode'(i_in.opcode))
            OP_SDEC: begin
                o_ctl.neg = w_num[VALUE_WIDTH-1];
                // most negative value wraps to itself, read as unsigned
                if (w_num[VALUE_WIDTH-1]) begin
                    o_mag = ~w_num + VALUE_WIDTH'(1);
                end
            end
            OP_UDEC: o_ctl.radix = RAD_DEC;
            OP_OCT:  o_ctl.radix = RAD_OCT;
            OP_HEXL: o_ctl.radix = RAD_HEX;
            OP_HEXU: begin
                o_ctl.radix = RAD_HEX;
                o_ctl.upper = 1'b1;
            end
            // undefined codes are taken and dropped
            default: w_known = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/itoa_fifo.sv @@
`default_nettype none

module itoa_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

@@ sv/itoa_back.sv @@
`default_nettype none

module itoa_back #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire logic [VALUE_WIDTH-1:0] i_mag,
    input  wire itoa_pkg::t_item_ctl    i_ctl,
    output logic                        o_pop,
    itoa_out_if.source                  o_out
);
    import itoa_pkg::*;

    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int NUM_DIGITS = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int PAD3_W     = 3 * NUM_DIGITS;
    localparam int PAD4_W     = 4 * NUM_DIGITS;

    t_state                  r_state, n_state;
    logic [3:0]              r_digits [NUM_DIGITS];
    logic [3:0]              n_digits [NUM_DIGITS];
    logic [VALUE_WIDTH-1:0]  r_bin, n_bin;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_neg, n_neg;
    logic                    r_upper, n_upper;
    logic                    r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]       r_char, n_char;
    logic                    r_last, n_last;

    logic [3:0]              w_adj [NUM_DIGITS];
    logic [3:0]              w_dab [NUM_DIGITS];
    logic [3:0]              w_oct [NUM_DIGITS];
    logic [3:0]              w_hex [NUM_DIGITS];
    logic [PAD3_W-1:0]       w_pad3;
    logic [PAD4_W-1:0]       w_pad4;
    logic                    w_slot;

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;
    assign w_slot         = !r_out_valid || o_out.ready;

    // one shift-add-3 step of binary to bcd, digits kept msd at the top
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[i] = (r_digits[i] >= 4'd5) ? r_digits[i] + 4'd3 : r_digits[i];
        end
        w_dab[0] = {w_adj[0][2:0], r_bin[VALUE_WIDTH-1]};
        for (int i = 1; i < NUM_DIGITS; i++) begin
            w_dab[i] = {w_adj[i][2:0], w_adj[i-1][3]};
        end
    end

    // octal and hex digits come straight from the bits
    assign w_pad3 = PAD3_W'(i_mag);
    assign w_pad4 = PAD4_W'(i_mag);
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_oct[i] = {1'b0, w_pad3[3*i +: 3]};
            w_hex[i] = w_pad4[4*i +: 4];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_digits    = r_digits;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_upper     = r_upper;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_neg   = i_ctl.neg;
                    n_upper = i_ctl.upper;
                    n_pos   = POS_W'(NUM_DIGITS - 1);
                    unique case (i_ctl.radix)
                        RAD_DEC: begin
                            for (int i = 0; i < NUM_DIGITS; i++) begin
                                n_digits[i] = 4'd0;
                            end
                            n_bin   = i_mag;
                            n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                            n_state = ST_CONV;
                        end
                        RAD_OCT: begin
                            n_digits = w_oct;
                            n_state  = ST_SKIP;
                        end
                        default: begin
                            n_digits = w_hex;
                            n_state  = ST_SKIP;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_digits = w_dab;
                n_bin    = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = ST_SKIP;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_SKIP: begin
                // drop leading zeros, always keep the lowest digit
                if (r_digits[r_pos] == 4'd0 && r_pos != '0) begin
                    n_pos = r_pos - POS_W'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_char(r_digits[r_pos], r_upper);
                    n_last      = (r_pos == '0);
                    if (r_pos == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos - POS_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_neg    <= n_neg;
        r_upper  <= n_upper;
        r_char   <= n_char;
        r_last   <= n_last;
    end

`ifndef SYNTH
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && !i_empty))
        else $error("queue popped outside idle");
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("minus sign for a non-negative item");
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN && w_slot) |=> (r_state == ST_EMIT && r_out_valid && !r_last))
        else $error("minus sign not followed by digits");
`endif

endmodule

`default_nettype wire

@@ sv/integer_to_ascii_radix.sv @@
// integer_to_ascii_radix: turns one number into its ascii text, one character per beat
//
// input channel i_in (valid/ready): value and opcode; opcode 0 signed decimal,
// 1 unsigned decimal, 2 octal, 3 lowercase hex, 4 uppercase hex. other opcodes
// are taken and give no output. output channel o_out (valid/ready): char_out,
// msd first, no leading zeros, '-' ahead of a negative signed decimal, with
// last set on the final character of each number.
// the front classifies and negates, then a QUEUE_DEPTH-entry queue (two by default) holds items for the
// converter, so a new item is taken while earlier text is still going out.
// for each item, octal/hex load their digits straight from the bits when popped, then
// run a leading-zero scan, then send one character per cycle while ready is high (22
// digit slots at 64 bits). decimal first runs a bit-serial binary to bcd loop over
// all VALUE_WIDTH bits, and a negative signed decimal sends a minus sign ahead of
// its digits.
// the first character appears after the queue, the conversion and the scan.
// reset (i_rst_n low, synchronous) empties the queue and drops any text in flight.
// when the receiver holds ready low the current character stays on o_out, the
// converter waits to send its next one, and i_in keeps accepting until the queue is full.
`default_nettype none

module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);
    import itoa_pkg::*;

    localparam int CTL_W  = $bits(t_item_ctl);
    localparam int ITEM_W = VALUE_WIDTH + CTL_W;

    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    logic [VALUE_WIDTH-1:0] w_front_mag;
    t_item_ctl              w_front_ctl;
    logic [ITEM_W-1:0]      w_q_data;
    t_item_ctl              w_back_ctl;
    logic [VALUE_WIDTH-1:0] w_back_mag;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_mag  (w_front_mag),
        .o_ctl  (w_front_ctl)
    );

    itoa_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_ctl, w_front_mag}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_empty)
    );

    assign w_back_ctl = t_item_ctl'(w_q_data[ITEM_W-1:VALUE_WIDTH]);
    assign w_back_mag = w_q_data[VALUE_WIDTH-1:0];

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_mag   (w_back_mag),
        .i_ctl   (w_back_ctl),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
